// ----- rtl/qepf_pkg.sv -----
// ----------------------------------------------------------------------------
// qepf_pkg
// Shared types, codes and constants of the quadrature edge period filter.
// ----------------------------------------------------------------------------
`default_nettype none

package qepf_pkg;

    localparam int MIN_PERIODS = 4;

    localparam logic [0:0] OP_EDGE  = 1'b0;
    localparam logic [0:0] OP_SPEED = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    localparam logic [1:0] REG_MIN_EDGE_INTERVAL = 2'd0;
    localparam logic [1:0] REG_REVERSAL_CONFIRM  = 2'd1;
    localparam logic [1:0] REG_AVERAGE_WINDOW    = 2'd2;
    localparam logic [1:0] REG_STOP_TIMEOUT      = 2'd3;

    localparam logic [31:0] RST_MIN_EDGE_INTERVAL = 32'd20000;
    localparam logic [3:0]  RST_REVERSAL_CONFIRM  = 4'd4;
    localparam logic [5:0]  RST_AVERAGE_WINDOW    = 6'd16;
    localparam logic [31:0] RST_STOP_TIMEOUT      = 32'd5000000;

    localparam logic [3:0] RC_MAX = 4'd15;

    typedef enum logic [2:0] {
        ES_NONE     = 3'd0,
        ES_ACCEPTED = 3'd1,
        ES_TOO_FAST = 3'd2,
        ES_PENDING  = 3'd3,
        ES_REVERSED = 3'd4
    } edge_status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_EXEC = 3'd1,
        ST_SUM  = 3'd2,
        ST_DIV  = 3'd3,
        ST_DONE = 3'd4
    } state_t;

    typedef struct packed {
        logic [31:0] min_edge_interval;
        logic [3:0]  reversal_confirm_count;
        logic [5:0]  average_window;
        logic [31:0] stop_timeout;
    } cfg_t;

    function automatic logic [1:0] decode_step(input logic [1:0] from, input logic [1:0] to);
        logic [1:0] d;
        unique case ({from, to})
            4'h1, 4'h7, 4'hE, 4'h8: d = DIR_NEG;
            4'h2, 4'hB, 4'hD, 4'h4: d = DIR_POS;
            default:                d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/quadrature_edge_period_filter_unit.sv -----
// ----------------------------------------------------------------------------
// quadrature_edge_period_filter_unit
// Quadrature decoder with glitch rejection, reversal confirmation and
// edge period averaging.
// ----------------------------------------------------------------------------
// One item is processed at a time. A pin sample goes from acceptance to a
// loaded result through the accept, execute and hand-over steps. A speed
// request walks the period ring through its single read port, one entry a
// cycle, for the window size w (at most RING_DEPTH), then runs the
// one-bit-per-cycle divider over the 32+clog2(RING_DEPTH+1)-bit sum when a
// mean is due. The ring needs no clearing pass: a fill count bounds every
// read to written entries. A new item is accepted while the previous
// result still waits on the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_edge_period_filter_unit
    import qepf_pkg::*;
#(
    parameter int RING_DEPTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pin_a[0], pin_b[1], timestamp[33:2], zero fill[39:34]
    input  wire logic [39:0]  s_tdata,
    // op[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // position[31:0], delta_count[63:32], direction[65:64], edge_status[68:66],
    // mean_period[100:69], stopped[101], speed_valid[102], zero fill[103]
    output logic      [103:0] m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int SW = 32 + FW;

    cfg_t cfg;

    state_t state_reg;
    state_t state_next;

    logic        item_op_reg;
    logic [1:0]  item_pins_reg;
    logic [31:0] item_ts_reg;

    logic [1:0]    prev_pins_reg;
    logic [31:0]   position_reg;
    logic [1:0]    stable_dir_reg;
    logic [3:0]    rc_reg;
    logic [31:0]   edge_time_reg;
    logic          edge_seen_reg;
    logic [AW-1:0] wr_idx_reg;
    logic [FW-1:0] fill_reg;
    logic [1:0]    speed_dir_reg;
    logic [31:0]   sampled_pos_reg;

    logic [FW-1:0] win_reg;
    logic [FW-1:0] issued_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          pend_reg;
    logic [SW-1:0] sum_reg;

    logic [31:0]  res_delta_reg;
    edge_status_t res_status_reg;
    logic [31:0]  res_mean_reg;
    logic         res_stopped_reg;
    logic         res_valid_reg;

    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;

    logic [1:0]    step;
    logic [31:0]   dt;
    logic [3:0]    rc_inc;
    edge_status_t  edge_cls;
    logic [FW-1:0] win_cap;
    logic [FW-1:0] win_calc;
    logic [AW-1:0] rd_prev;
    logic          issue;
    logic          sum_end;
    logic          div_go;
    logic          out_free;

    logic          mem_we;
    logic          mem_re;
    logic [31:0]   mem_rdata;
    logic          div_start;
    logic          div_done;
    logic [SW-1:0] div_quo;

    qepf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qepf_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_idx_reg),
        .wdata (dt),
        .re    (mem_re),
        .raddr (rd_prev),
        .rdata (mem_rdata)
    );

    qepf_divider #(
        .DW (SW),
        .VW (FW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        step   = decode_step(prev_pins_reg, item_pins_reg);
        dt     = item_ts_reg - edge_time_reg;
        rc_inc = (rc_reg != RC_MAX) ? rc_reg + 4'd1 : rc_reg;
        if (step == DIR_NONE)
            edge_cls = ES_NONE;
        else if (edge_seen_reg && (dt < cfg.min_edge_interval))
            edge_cls = ES_TOO_FAST;
        else if ((stable_dir_reg != DIR_NONE) && (step != stable_dir_reg))
            edge_cls = (rc_inc < cfg.reversal_confirm_count) ? ES_PENDING : ES_REVERSED;
        else
            edge_cls = ES_ACCEPTED;
    end

    always_comb
    begin
        if (32'(cfg.average_window) > 32'(RING_DEPTH))
            win_cap = FW'(RING_DEPTH);
        else
            win_cap = FW'(cfg.average_window);
        win_calc = (win_cap > fill_reg) ? fill_reg : win_cap;
        rd_prev  = (rd_idx_reg == '0) ? AW'(RING_DEPTH - 1) : rd_idx_reg - 1'b1;
        issue    = issued_reg != win_reg;
        sum_end  = !issue && !pend_reg;
        div_go   = !res_stopped_reg && (32'(win_reg) >= 32'(MIN_PERIODS))
                   && (sum_reg != '0);
        out_free = !m_tvalid_reg || m_tready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: state_next = (item_op_reg == OP_SPEED) ? ST_SUM : ST_DONE;
            ST_SUM:  if (sum_end) state_next = div_go ? ST_DIV : ST_DONE;
            ST_DIV:  if (div_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = state_reg == ST_IDLE;
        mem_we    = (state_reg == ST_EXEC) && (item_op_reg == OP_EDGE)
                    && (edge_cls == ES_ACCEPTED) && edge_seen_reg;
        mem_re    = (state_reg == ST_SUM) && issue;
        div_start = (state_reg == ST_SUM) && sum_end && div_go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg   <= 2'b00;
            position_reg    <= '0;
            stable_dir_reg  <= DIR_NONE;
            rc_reg          <= '0;
            edge_time_reg   <= '0;
            edge_seen_reg   <= 1'b0;
            wr_idx_reg      <= '0;
            fill_reg        <= '0;
            speed_dir_reg   <= DIR_POS;
            sampled_pos_reg <= '0;
            pend_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_EXEC:
                begin
                    if (item_op_reg == OP_EDGE)
                    begin
                        if (edge_cls != ES_TOO_FAST)
                            prev_pins_reg <= item_pins_reg;
                        if (edge_cls == ES_PENDING)
                            rc_reg <= rc_inc;
                        if (edge_cls == ES_ACCEPTED || edge_cls == ES_REVERSED)
                        begin
                            stable_dir_reg <= step;
                            rc_reg         <= '0;
                            position_reg   <= position_reg + {{30{step[1]}}, step};
                            speed_dir_reg  <= step;
                            edge_time_reg  <= item_ts_reg;
                            edge_seen_reg  <= 1'b1;
                        end
                        if (edge_cls == ES_REVERSED)
                        begin
                            wr_idx_reg <= '0;
                            fill_reg   <= '0;
                        end
                        if (mem_we)
                        begin
                            wr_idx_reg <= (wr_idx_reg == AW'(RING_DEPTH - 1)) ?
                                          '0 : wr_idx_reg + 1'b1;
                            if (fill_reg != FW'(RING_DEPTH))
                                fill_reg <= fill_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sampled_pos_reg <= position_reg;
                    end
                    pend_reg <= 1'b0;
                end
                ST_SUM:
                begin
                    pend_reg <= issue;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    item_op_reg   <= s_tuser;
                    item_pins_reg <= s_tdata[1:0] == 2'b00 ? 2'b00 :
                                     {s_tdata[0], s_tdata[1]};
                    item_ts_reg   <= s_tdata[33:2];
                end
            end
            ST_EXEC:
            begin
                res_mean_reg  <= '0;
                res_valid_reg <= 1'b0;
                win_reg       <= win_calc;
                issued_reg    <= '0;
                rd_idx_reg    <= wr_idx_reg;
                sum_reg       <= '0;
                if (item_op_reg == OP_EDGE)
                begin
                    res_delta_reg   <= '0;
                    res_status_reg  <= edge_cls;
                    res_stopped_reg <= 1'b0;
                end
                else
                begin
                    res_delta_reg   <= position_reg - sampled_pos_reg;
                    res_status_reg  <= ES_NONE;
                    res_stopped_reg <= !edge_seen_reg ||
                                       ((item_ts_reg - edge_time_reg) > cfg.stop_timeout);
                end
            end
            ST_SUM:
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_prev;
                    issued_reg <= issued_reg + 1'b1;
                end
                if (pend_reg)
                    sum_reg <= sum_reg + SW'(mem_rdata);
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_mean_reg  <= div_quo[31:0];
                    res_valid_reg <= 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    m_tdata_reg <= {1'b0, res_valid_reg, res_stopped_reg, res_mean_reg,
                                    res_status_reg, speed_dir_reg, res_delta_reg,
                                    position_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- rtl/qepf_cfg.sv -----
// ----------------------------------------------------------------------------
// qepf_cfg
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module qepf_cfg
    import qepf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_edge_interval      <= RST_MIN_EDGE_INTERVAL;
            cfg_reg.reversal_confirm_count <= RST_REVERSAL_CONFIRM;
            cfg_reg.average_window         <= RST_AVERAGE_WINDOW;
            cfg_reg.stop_timeout           <= RST_STOP_TIMEOUT;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_MIN_EDGE_INTERVAL: cfg_reg.min_edge_interval      <= pwdata;
                REG_REVERSAL_CONFIRM:  cfg_reg.reversal_confirm_count <= pwdata[3:0];
                REG_AVERAGE_WINDOW:    cfg_reg.average_window         <= pwdata[5:0];
                REG_STOP_TIMEOUT:      cfg_reg.stop_timeout           <= pwdata;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MIN_EDGE_INTERVAL: prdata = cfg_reg.min_edge_interval;
            REG_REVERSAL_CONFIRM:  prdata = {28'd0, cfg_reg.reversal_confirm_count};
            REG_AVERAGE_WINDOW:    prdata = {26'd0, cfg_reg.average_window};
            REG_STOP_TIMEOUT:      prdata = cfg_reg.stop_timeout;
            default:               prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/qepf_ring_mem.sv -----
// ----------------------------------------------------------------------------
// qepf_ring_mem
// Period ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qepf_ring_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/qepf_divider.sv -----
// ----------------------------------------------------------------------------
// qepf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qepf_divider #(
    parameter int DW = 38,
    parameter int VW = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic      [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign fits     = trial >= {1'b0, div_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(trial - {1'b0, div_reg}) : trial[VW-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_quadrature_edge_period_filter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_quadrature_edge_period_filter_unit
// Self-checking bench for the quadrature edge period filter: drives pin
// samples and speed requests over the input stream, programs the filter
// registers over APB while the block is idle, predicts every report and
// compares it field by field with the output stream under random stalls.
// ----------------------------------------------------------------------------
module tb_quadrature_edge_period_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import qepf_pkg::*;

    localparam int RING         = 32;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_ITEMS  = 135;

    typedef struct {
        logic [31:0]  position;
        logic [31:0]  delta_count;
        logic [1:0]   direction;
        edge_status_t edge_status;
        logic [31:0]  mean_period;
        logic         stopped;
        logic         speed_valid;
    } qe_report_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [39:0]  s_tdata  = '0;
    logic         s_tuser  = 1'b0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [103:0] m_tdata;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    wire  [31:0]  prdata;
    wire          pready;

    quadrature_edge_period_filter_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    logic [31:0] cfg_min_gap   = RST_MIN_EDGE_INTERVAL;
    logic [3:0]  cfg_confirm   = RST_REVERSAL_CONFIRM;
    logic [5:0]  cfg_window    = RST_AVERAGE_WINDOW;
    logic [31:0] cfg_timeout   = RST_STOP_TIMEOUT;

    logic [1:0]  pin_state     = 2'b00;
    logic [31:0] pos_count     = '0;
    logic [1:0]  settled_dir   = DIR_NONE;
    logic [3:0]  opp_edges     = '0;
    logic [31:0] edge_ts       = '0;
    logic        edge_known    = 1'b0;
    logic [31:0] periods [RING];
    logic [4:0]  wr_ptr        = '0;
    logic [5:0]  fill_cnt      = '0;
    logic [1:0]  rate_dir      = DIR_POS;
    logic [31:0] pos_at_sample = '0;

    qe_report_t  report_queue [$];

    logic [31:0] set_min     [7] = '{32'd20000, 32'd1000, 32'd0, 32'd50,
                                     32'hFFFF_FFFF, 32'd300, 32'd2000};
    logic [31:0] set_confirm [7] = '{32'd4, 32'd1, 32'd0, 32'd15, 32'd2, 32'd3, 32'd7};
    logic [31:0] set_window  [7] = '{32'd16, 32'd4, 32'd32, 32'd63, 32'd5, 32'd0, 32'd12};
    logic [31:0] set_timeout [7] = '{32'd5000000, 32'd200000, 32'hFFFF_FFFF, 32'd0,
                                     32'd1000, 32'd100000, 32'd50000};

    logic [1:0]  motion_dir     = DIR_POS;
    logic [31:0] now_ts         = 32'hFFFF_0000;
    int          send_idle_pct  = 10;
    int          recv_stall_pct = 87;
    logic        hold_kick      = 1'b0;
    logic        hold_seen      = 1'b0;
    int          hold_left      = 0;
    int          idle_cycles    = 0;
    int          error_count    = 0;
    int          n_items        = 0;
    int          n_reports      = 0;
    int          n_accepted     = 0;
    int          n_too_fast     = 0;
    int          n_pending      = 0;
    int          n_reversed     = 0;
    int          n_speed_valid  = 0;
    int          n_stopped      = 0;

    function automatic logic [1:0] gray_pos(input logic [1:0] p);
        case (p)
            2'b00:   return 2'd0;
            2'b10:   return 2'd1;
            2'b11:   return 2'd2;
            default: return 2'd3;
        endcase
    endfunction

    function automatic logic [1:0] gray_step(input logic [1:0] from, input logic [1:0] to);
        logic [1:0] diff;
        diff = gray_pos(to) - gray_pos(from);
        if (diff == 2'd1)
            return DIR_POS;
        if (diff == 2'd3)
            return DIR_NEG;
        return DIR_NONE;
    endfunction

    function automatic logic [1:0] gray_next(input logic [1:0] p, input logic [1:0] dir);
        logic [1:0] slot;
        slot = gray_pos(p) + ((dir == DIR_POS) ? 2'd1 : 2'd3);
        case (slot)
            2'd0:    return 2'b00;
            2'd1:    return 2'b10;
            2'd2:    return 2'b11;
            default: return 2'b01;
        endcase
    endfunction

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] edge_gap(input logic glitch);
        if (glitch && cfg_min_gap != 0)
            return $urandom_range(cfg_min_gap - 1);
        return clamp32(64'(cfg_min_gap) +
                       $urandom_range((cfg_min_gap == 0) ? 1 : cfg_min_gap));
    endfunction

    function automatic logic [31:0] speed_gap();
        if ($urandom_range(99) < 20)
            return clamp32(64'(cfg_timeout) + $urandom_range(1000, 1));
        return $urandom_range((cfg_min_gap == 0) ? 100 : cfg_min_gap);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic predict_report(input logic op, input logic pa, input logic pb,
                                  input logic [31:0] ts, output qe_report_t r);
        logic [1:0]  cur;
        logic [1:0]  d;
        logic [31:0] dt;
        logic [63:0] acc;
        logic [4:0]  idx;
        int          win;
        r.delta_count = '0;
        r.edge_status = ES_NONE;
        r.mean_period = '0;
        r.stopped     = 1'b0;
        r.speed_valid = 1'b0;
        dt = ts - edge_ts;
        if (op == OP_EDGE[0]) begin
            cur = {pa, pb};
            d   = gray_step(pin_state, cur);
            if (d == DIR_NONE) begin
                pin_state = cur;
            end
            else if (edge_known && dt < cfg_min_gap) begin
                r.edge_status = ES_TOO_FAST;
            end
            else if (settled_dir != DIR_NONE && d != settled_dir) begin
                if (opp_edges < RC_MAX)
                    opp_edges++;
                if (opp_edges < cfg_confirm) begin
                    r.edge_status = ES_PENDING;
                end
                else begin
                    settled_dir   = d;
                    opp_edges     = '0;
                    pos_count     = (d == DIR_POS) ? pos_count + 1 : pos_count - 1;
                    wr_ptr        = '0;
                    fill_cnt      = '0;
                    edge_ts       = ts;
                    edge_known    = 1'b1;
                    rate_dir      = d;
                    r.edge_status = ES_REVERSED;
                end
                pin_state = cur;
            end
            else begin
                settled_dir = d;
                opp_edges   = '0;
                if (edge_known) begin
                    periods[wr_ptr] = dt;
                    wr_ptr++;
                    if (fill_cnt < RING)
                        fill_cnt++;
                end
                pos_count     = (d == DIR_POS) ? pos_count + 1 : pos_count - 1;
                rate_dir      = d;
                edge_ts       = ts;
                edge_known    = 1'b1;
                r.edge_status = ES_ACCEPTED;
                pin_state     = cur;
            end
        end
        else begin
            r.delta_count = pos_count - pos_at_sample;
            pos_at_sample = pos_count;
            win = cfg_window;
            if (win > RING)
                win = RING;
            if (win > fill_cnt)
                win = fill_cnt;
            acc = '0;
            idx = wr_ptr;
            for (int i = 0; i < win; i++) begin
                idx--;
                acc += periods[idx];
            end
            if (!edge_known || dt > cfg_timeout) begin
                r.stopped = 1'b1;
            end
            else if (win >= MIN_PERIODS && acc != 0) begin
                r.mean_period = 32'(acc / 64'(win));
                r.speed_valid = 1'b1;
            end
        end
        r.position  = pos_count;
        r.direction = rate_dir;
    endtask

    task automatic send_item(input logic op, input logic pa, input logic pb,
                             input logic [31:0] ts);
        qe_report_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, ts, pb, pa};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_report(op, pa, pb, ts, want);
        report_queue.push_back(want);
        n_items++;
        @(negedge clk);
    endtask

    task automatic edge_step(input logic [1:0] pins, input logic [31:0] dt);
        now_ts = now_ts + dt;
        send_item(OP_EDGE[0], pins[1], pins[0], now_ts);
    endtask

    task automatic speed_step(input logic [31:0] dt);
        now_ts = now_ts + dt;
        send_item(OP_SPEED[0], 1'($urandom_range(1)), 1'($urandom_range(1)), now_ts);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (report_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_EDGE_INTERVAL: cfg_min_gap = val;
            REG_REVERSAL_CONFIRM:  cfg_confirm = val[3:0];
            REG_AVERAGE_WINDOW:    cfg_window  = val[5:0];
            REG_STOP_TIMEOUT:      cfg_timeout = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_setting(input int k);
        settle();
        program_reg(REG_MIN_EDGE_INTERVAL, set_min[k]);
        program_reg(REG_REVERSAL_CONFIRM, set_confirm[k]);
        program_reg(REG_AVERAGE_WINDOW, set_window[k]);
        program_reg(REG_STOP_TIMEOUT, set_timeout[k]);
    endtask

    task automatic random_walk(input int count);
        int         roll;
        logic [1:0] pins;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                speed_step(speed_gap());
            end
            else if (roll < 20) begin
                edge_step(2'($urandom_range(3)),
                          ($urandom_range(1) != 0) ? $urandom() : edge_gap(1'b0));
            end
            else begin
                if ($urandom_range(99) < 6)
                    motion_dir = (motion_dir == DIR_POS) ? DIR_NEG : DIR_POS;
                pins = gray_next(pin_state, motion_dir);
                edge_step(pins, edge_gap($urandom_range(99) < 15));
            end
        end
    endtask

    task automatic test_decode_directed();
        speed_step(32'd0);
        edge_step(2'b00, 32'd10);
        edge_step(2'b11, 32'd10);
        edge_step(2'b01, 32'd10);
        edge_step(2'b00, 32'd100);
        edge_step(2'b00, 32'd30000);
        edge_step(2'b10, 32'd30000);
        edge_step(2'b11, 32'd30000);
        edge_step(2'b01, 32'd30000);
        speed_step(32'd1000);
        edge_step(2'b11, 32'd30000);
        edge_step(2'b10, 32'd30000);
        edge_step(2'b00, 32'd30000);
        edge_step(2'b01, 32'd30000);
        speed_step(32'd10);
        edge_step(2'b11, 32'hFFFF_FFFF);
        speed_step(32'd6000000);
    endtask

    task automatic test_register_corners();
        settle();
        program_reg(REG_MIN_EDGE_INTERVAL, 32'd0);
        program_reg(REG_AVERAGE_WINDOW, 32'd4);
        program_reg(REG_REVERSAL_CONFIRM, 32'd0);
        edge_step(gray_next(pin_state, DIR_NEG), 32'd0);
        repeat (4)
            edge_step(gray_next(pin_state, DIR_NEG), 32'd0);
        speed_step(32'd0);
        edge_step(gray_next(pin_state, DIR_POS), 32'd0);
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int first_set);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int j = 0; j < 3; j++) begin
            apply_setting((first_set + j) % 7);
            random_walk(PHASE_ITEMS);
        end
    endtask

    task automatic test_output_backpressure();
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_kick      = ~hold_kick;
        random_walk(40);
    endtask

    always @(negedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin : check_reports
        qe_report_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (report_queue.size() == 0) begin
                $error("report %h arrived with none pending", m_tdata);
                error_count++;
            end
            else begin
                want = report_queue.pop_front();
                check_field("position", want.position, m_tdata[31:0]);
                check_field("delta_count", want.delta_count, m_tdata[63:32]);
                check_field("direction", want.direction, m_tdata[65:64]);
                check_field("edge_status", want.edge_status, m_tdata[68:66]);
                check_field("mean_period", want.mean_period, m_tdata[100:69]);
                check_field("stopped", want.stopped, m_tdata[101]);
                check_field("speed_valid", want.speed_valid, m_tdata[102]);
                n_reports++;
                case (want.edge_status)
                    ES_ACCEPTED: n_accepted++;
                    ES_TOO_FAST: n_too_fast++;
                    ES_PENDING:  n_pending++;
                    ES_REVERSED: n_reversed++;
                    default: ;
                endcase
                if (want.speed_valid)
                    n_speed_valid++;
                if (want.stopped)
                    n_stopped++;
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end
        else if (rst_n) begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("** quadrature_edge_period_filter_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_decode_directed();
        test_register_corners();
        test_random_traffic(10, 87, 0);
        test_random_traffic(87, 10, 3);
        test_random_traffic(0, 0, 6);
        test_output_backpressure();
        settle();
        $display("%0d items sent, %0d reports checked; edges: %0d counted, %0d glitches, %0d pending, %0d reversals",
                 n_items, n_reports, n_accepted, n_too_fast, n_pending, n_reversed);
        $display("speed reports: %0d with a valid mean, %0d stopped, over 7 register sets",
                 n_speed_valid, n_stopped);
        if (error_count == 0)
            $display("** quadrature_edge_period_filter_unit: PASSED **");
        else
            $display("** quadrature_edge_period_filter_unit: FAILED **");
        $finish;
    end

endmodule
